// ===== design/sid_pkg.sv =====
// ----------------------------------------------------------------------------
// sid_pkg
// Shared types and constants for the 2D segment intersection block.
// ----------------------------------------------------------------------------
package sid_pkg;

    localparam int COORD_WIDTH_DEF = 16;
    localparam int FRAC_BITS_DEF   = 16;
    localparam int THR_W           = 35;
    localparam logic [THR_W-1:0] THR_RESET = 35'd1;

    // front-to-back queue
    localparam int QDEPTH = 8;
    localparam int QCW    = 4;

    typedef enum logic [1:0] {
        ST_NONE     = 2'd0,
        ST_HIT      = 2'd1,
        ST_PARALLEL = 2'd2
    } status_t;

    // classification of one item, decided in the front part
    typedef struct packed {
        status_t status;
        logic    t_zero;
        logic    t_one;
        logic    u_zero;
        logic    u_one;
    } cls_t;

endpackage

// ===== design/sid_queue.sv =====
// ----------------------------------------------------------------------------
// sid_queue
// Small register FIFO between the front and back parts, with occupancy count.
// ----------------------------------------------------------------------------
module sid_queue #(
    parameter int DW    = 8,
    parameter int DEPTH = 8,
    parameter int CW    = 4
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  logic [DW-1:0] push_data,
    input  logic          pop,
    output logic [DW-1:0] head_data,
    output logic          not_empty,
    output logic [CW-1:0] count
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [DW-1:0] mem_reg [DEPTH];
    logic [AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    assign head_data = mem_reg[rd_ptr_reg];
    assign not_empty = (count_reg != '0);
    assign count     = count_reg;

endmodule

// ===== design/sid_front.sv =====
// ----------------------------------------------------------------------------
// sid_front
// Three-stage pipeline: endpoint differences, products, sums; then side
// tests, parallel test and quotient range checks on the way into the queue.
// ----------------------------------------------------------------------------
module sid_front #(
    parameter int COORD_WIDTH = 16,
    parameter int MW          = 35
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    input  logic [8*COORD_WIDTH-1:0] in_data,
    output logic                     in_ready,
    input  logic [sid_pkg::THR_W-1:0] thr,
    input  logic [sid_pkg::QCW-1:0]  q_count,
    output logic                     push,
    output sid_pkg::cls_t            cls,
    output logic [MW-1:0]            num_t,
    output logic [MW-1:0]            num_u,
    output logic [MW-1:0]            den
);
    import sid_pkg::*;

    localparam int W  = COORD_WIDTH;
    localparam int DW = W + 1;
    localparam int PW = 2 * W + 2;
    localparam int CW = (MW > THR_W) ? MW : THR_W;

    logic signed [W-1:0] x1, y1, x2, y2, x3, y3, x4, y4;

    // stage 1: differences
    logic                 s1_v_reg;
    logic signed [DW-1:0] a1_reg, b1_reg, a2_reg, b2_reg;
    logic signed [DW-1:0] e31_reg, f31_reg, e41_reg, f41_reg;
    logic signed [DW-1:0] e13_reg, f13_reg, e23_reg, f23_reg;

    // stage 2: products
    logic                 s2_v_reg;
    logic signed [PW-1:0] p_a1e31_reg, p_b1f31_reg, p_a1e41_reg, p_b1f41_reg;
    logic signed [PW-1:0] p_a2e13_reg, p_b2f13_reg, p_a2e23_reg, p_b2f23_reg;
    logic signed [PW-1:0] p_a1b2_reg, p_a2b1_reg, p_b2f31_reg, p_a2e31_reg;

    // stage 3: line side values, determinant, numerators
    logic                 s3_v_reg;
    logic signed [MW-1:0] r1_reg, r2_reg, r3_reg, r4_reg, den_reg, tn_reg;

    logic [QCW-1:0] inflight;
    logic           accept;

    assign x1 = in_data[1*W-1:0*W];
    assign y1 = in_data[2*W-1:1*W];
    assign x2 = in_data[3*W-1:2*W];
    assign y2 = in_data[4*W-1:3*W];
    assign x3 = in_data[5*W-1:4*W];
    assign y3 = in_data[6*W-1:5*W];
    assign x4 = in_data[7*W-1:6*W];
    assign y4 = in_data[8*W-1:7*W];

    // credit check: everything in flight must fit in the queue
    assign inflight = q_count + QCW'(s1_v_reg) + QCW'(s2_v_reg) + QCW'(s3_v_reg);
    assign in_ready = (inflight < QCW'(QDEPTH));
    assign accept   = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_v_reg <= 1'b0;
            s2_v_reg <= 1'b0;
            s3_v_reg <= 1'b0;
        end
        else
        begin
            s1_v_reg <= accept;
            s2_v_reg <= s1_v_reg;
            s3_v_reg <= s2_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        a1_reg  <= DW'(y2) - DW'(y1);
        b1_reg  <= DW'(x1) - DW'(x2);
        a2_reg  <= DW'(y4) - DW'(y3);
        b2_reg  <= DW'(x3) - DW'(x4);
        e31_reg <= DW'(x3) - DW'(x1);
        f31_reg <= DW'(y3) - DW'(y1);
        e41_reg <= DW'(x4) - DW'(x1);
        f41_reg <= DW'(y4) - DW'(y1);
        e13_reg <= DW'(x1) - DW'(x3);
        f13_reg <= DW'(y1) - DW'(y3);
        e23_reg <= DW'(x2) - DW'(x3);
        f23_reg <= DW'(y2) - DW'(y3);

        p_a1e31_reg <= PW'(a1_reg) * PW'(e31_reg);
        p_b1f31_reg <= PW'(b1_reg) * PW'(f31_reg);
        p_a1e41_reg <= PW'(a1_reg) * PW'(e41_reg);
        p_b1f41_reg <= PW'(b1_reg) * PW'(f41_reg);
        p_a2e13_reg <= PW'(a2_reg) * PW'(e13_reg);
        p_b2f13_reg <= PW'(b2_reg) * PW'(f13_reg);
        p_a2e23_reg <= PW'(a2_reg) * PW'(e23_reg);
        p_b2f23_reg <= PW'(b2_reg) * PW'(f23_reg);
        p_a1b2_reg  <= PW'(a1_reg) * PW'(b2_reg);
        p_a2b1_reg  <= PW'(a2_reg) * PW'(b1_reg);
        p_b2f31_reg <= PW'(b2_reg) * PW'(f31_reg);
        p_a2e31_reg <= PW'(a2_reg) * PW'(e31_reg);

        // side values taken relative to an endpoint of the other line;
        // the u numerator equals r3
        r3_reg  <= MW'(p_a1e31_reg) + MW'(p_b1f31_reg);
        r4_reg  <= MW'(p_a1e41_reg) + MW'(p_b1f41_reg);
        r1_reg  <= MW'(p_a2e13_reg) + MW'(p_b2f13_reg);
        r2_reg  <= MW'(p_a2e23_reg) + MW'(p_b2f23_reg);
        den_reg <= MW'(p_a1b2_reg) - MW'(p_a2b1_reg);
        tn_reg  <= MW'(p_b2f31_reg) + MW'(p_a2e31_reg);
    end

    logic          same12, same34, par;
    logic [MW-1:0] dmag, tmag, umag;

    assign same34 = (r3_reg != '0) && (r4_reg != '0) && (r3_reg[MW-1] == r4_reg[MW-1]);
    assign same12 = (r1_reg != '0) && (r2_reg != '0) && (r1_reg[MW-1] == r2_reg[MW-1]);
    assign dmag   = den_reg[MW-1] ? MW'(-den_reg) : MW'(den_reg);
    assign tmag   = tn_reg[MW-1]  ? MW'(-tn_reg)  : MW'(tn_reg);
    assign umag   = r3_reg[MW-1]  ? MW'(-r3_reg)  : MW'(r3_reg);
    assign par    = (den_reg == '0) || (CW'(dmag) < CW'(thr));

    always_comb
    begin
        cls.status = ST_HIT;
        if (same34 || same12)
        begin
            cls.status = ST_NONE;
        end
        else if (par)
        begin
            cls.status = ST_PARALLEL;
        end
        cls.t_zero = (tn_reg == '0) || (tn_reg[MW-1] != den_reg[MW-1]);
        cls.t_one  = (tmag >= dmag);
        cls.u_zero = (r3_reg == '0) || (r3_reg[MW-1] != den_reg[MW-1]);
        cls.u_one  = (umag >= dmag);
    end

    assign push  = s3_v_reg;
    assign num_t = tmag;
    assign num_u = umag;
    assign den   = dmag;

endmodule

// ===== design/sid_back.sv =====
// ----------------------------------------------------------------------------
// sid_back
// Pipelined restoring divider, one quotient bit per stage for t and u,
// followed by saturation and the output register.
// ----------------------------------------------------------------------------
module sid_back #(
    parameter int FRAC_BITS = 16,
    parameter int MW        = 35,
    parameter int OUT_W     = 40
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_pop,
    input  sid_pkg::cls_t    in_cls,
    input  logic [MW-1:0]    in_num_t,
    input  logic [MW-1:0]    in_num_u,
    input  logic [MW-1:0]    in_den,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [OUT_W-1:0] out_data
);
    import sid_pkg::*;

    localparam int F = FRAC_BITS;

    logic          adv;
    logic          v_reg     [F];
    cls_t          cls_reg   [F];
    logic [MW-1:0] d_reg     [F];
    logic [MW-1:0] rem_t_reg [F];
    logic [MW-1:0] rem_u_reg [F];
    logic [F-1:0]  q_t_reg   [F];
    logic [F-1:0]  q_u_reg   [F];

    logic          out_v_reg;
    status_t       st_reg;
    logic [F:0]    t_reg, u_reg;

    // the whole back part moves together; the output register parts it from
    // the consumer
    assign adv    = !out_v_reg || out_ready;
    assign in_pop = adv && in_valid;

    genvar k;
    generate
        for (k = 0; k < F; k++)
        begin : g_stage
            logic [MW-1:0] rt_in, ru_in, d_in;
            logic [F-1:0]  qt_in, qu_in;
            logic [MW:0]   st, su;
            logic          gt, gu;

            if (k == 0)
            begin : g_first
                assign rt_in = in_num_t;
                assign ru_in = in_num_u;
                assign d_in  = in_den;
                assign qt_in = '0;
                assign qu_in = '0;
            end
            else
            begin : g_next
                assign rt_in = rem_t_reg[k-1];
                assign ru_in = rem_u_reg[k-1];
                assign d_in  = d_reg[k-1];
                assign qt_in = q_t_reg[k-1];
                assign qu_in = q_u_reg[k-1];
            end

            assign st = {rt_in, 1'b0};
            assign su = {ru_in, 1'b0};
            assign gt = (st >= {1'b0, d_in});
            assign gu = (su >= {1'b0, d_in});

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    v_reg[k] <= 1'b0;
                end
                else if (adv)
                begin
                    v_reg[k] <= (k == 0) ? in_valid : v_reg[(k == 0) ? 0 : k - 1];
                end
            end

            always_ff @(posedge clk)
            begin
                if (adv)
                begin
                    cls_reg[k]   <= (k == 0) ? in_cls : cls_reg[(k == 0) ? 0 : k - 1];
                    d_reg[k]     <= d_in;
                    rem_t_reg[k] <= gt ? MW'(st - {1'b0, d_in}) : MW'(st);
                    rem_u_reg[k] <= gu ? MW'(su - {1'b0, d_in}) : MW'(su);
                    q_t_reg[k]   <= {qt_in[F-2:0], gt};
                    q_u_reg[k]   <= {qu_in[F-2:0], gu};
                end
            end
        end
    endgenerate

    cls_t       c_last;
    logic [F:0] t_next, u_next;

    assign c_last = cls_reg[F-1];

    always_comb
    begin
        t_next = '0;
        u_next = '0;
        if (c_last.status == ST_HIT)
        begin
            if (!c_last.t_zero)
            begin
                t_next = c_last.t_one ? {1'b1, {F{1'b0}}} : {1'b0, q_t_reg[F-1]};
            end
            if (!c_last.u_zero)
            begin
                u_next = c_last.u_one ? {1'b1, {F{1'b0}}} : {1'b0, q_u_reg[F-1]};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_v_reg <= 1'b0;
        end
        else if (adv)
        begin
            out_v_reg <= v_reg[F-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            st_reg <= c_last.status;
            t_reg  <= t_next;
            u_reg  <= u_next;
        end
    end

    assign out_valid = out_v_reg;
    assign out_data  = OUT_W'({u_reg, t_reg, st_reg});

endmodule

// ===== design/segment_intersection_2d.sv =====
// ----------------------------------------------------------------------------
// segment_intersection_2d
// Tests two 2D segments for intersection and gives the Q1.FRAC_BITS
// positions of the crossing along each.
// ----------------------------------------------------------------------------
//  channel      dir  fields (lowest bit up)
//  s_axis       in   x1 y1 x2 y2 x3 y3 x4 y4, COORD_WIDTH bits each
//  m_axis       out  status[2], t_frac[FRAC_BITS+1], u_frac[FRAC_BITS+1]
//  cfg_wr_*     in   parallel_threshold, 35 bits
//
//  One item per cycle while neither side stalls. Items pass through the
//  three front stages, the queue, one divider stage per fraction bit, and
//  the output register. The front takes items while the 8-entry queue has
//  room for all items in flight; the back stalls as a whole on m_axis_tready.
//  Reset clears all valid state and sets the threshold to 1.
// ----------------------------------------------------------------------------
module segment_intersection_2d #(
    parameter int COORD_WIDTH = sid_pkg::COORD_WIDTH_DEF,
    parameter int FRAC_BITS   = sid_pkg::FRAC_BITS_DEF
) (
    input  logic clk,
    input  logic rst_n,
    // x1, y1, x2, y2, x3, y3, x4, y4
    input  logic [((8*COORD_WIDTH+7)/8)*8-1:0] s_axis_tdata,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // status, t_frac, u_frac
    output logic [((2*FRAC_BITS+4+7)/8)*8-1:0] m_axis_tdata,
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    input  logic                               cfg_wr_en,
    input  logic [sid_pkg::THR_W-1:0]          cfg_wr_data
);
    import sid_pkg::*;

    localparam int MW    = 2 * COORD_WIDTH + 3;
    localparam int OUT_W = ((2 * FRAC_BITS + 4 + 7) / 8) * 8;
    localparam int CLW   = $bits(cls_t);
    localparam int QW    = CLW + 3 * MW;

    logic [THR_W-1:0] thr_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg <= THR_RESET;
        end
        else if (cfg_wr_en)
        begin
            thr_reg <= cfg_wr_data;
        end
    end

    logic          push, pop, q_ne;
    logic [QCW-1:0] q_count;
    cls_t          f_cls, b_cls;
    logic [MW-1:0] f_nt, f_nu, f_d, b_nt, b_nu, b_d;
    logic [QW-1:0] q_head;

    sid_front #(
        .COORD_WIDTH (COORD_WIDTH),
        .MW          (MW)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_data  (s_axis_tdata[8*COORD_WIDTH-1:0]),
        .in_ready (s_axis_tready),
        .thr      (thr_reg),
        .q_count  (q_count),
        .push     (push),
        .cls      (f_cls),
        .num_t    (f_nt),
        .num_u    (f_nu),
        .den      (f_d)
    );

    sid_queue #(
        .DW    (QW),
        .DEPTH (QDEPTH),
        .CW    (QCW)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data ({f_cls, f_nt, f_nu, f_d}),
        .pop       (pop),
        .head_data (q_head),
        .not_empty (q_ne),
        .count     (q_count)
    );

    assign b_cls = q_head[QW-1:3*MW];
    assign b_nt  = q_head[3*MW-1:2*MW];
    assign b_nu  = q_head[2*MW-1:MW];
    assign b_d   = q_head[MW-1:0];

    sid_back #(
        .FRAC_BITS (FRAC_BITS),
        .MW        (MW),
        .OUT_W     (OUT_W)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (q_ne),
        .in_pop    (pop),
        .in_cls    (b_cls),
        .in_num_t  (b_nt),
        .in_num_u  (b_nu),
        .in_den    (b_d),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (m_axis_tdata)
    );

endmodule

// ===== bench/segment_intersection_2d_tb.sv =====
// ----------------------------------------------------------------------------
// segment_intersection_2d_tb
// Drives segment pairs through the intersection block and checks status and
// the t/u positions of every result against an in-bench exact-integer
// prediction, over several threshold settings and handshake idling mixes.
// ----------------------------------------------------------------------------
module segment_intersection_2d_tb;
    import sid_pkg::*;

    localparam int CW  = 16;
    localparam int FB  = 16;
    localparam int LAT = 4 + FB + 1;
    localparam int IW  = ((8*CW+7)/8)*8;
    localparam int OW  = ((2*FB+4+7)/8)*8;

    typedef struct packed {
        status_t         status;
        logic [FB:0]     t_frac;
        logic [FB:0]     u_frac;
    } isect_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic [IW-1:0] s_axis_tdata = '0;
    logic s_axis_tvalid = 1'b0;
    logic s_axis_tready;
    logic [OW-1:0] m_axis_tdata;
    logic m_axis_tvalid;
    logic m_axis_tready = 1'b0;
    logic cfg_wr_en = 1'b0;
    logic [THR_W-1:0] cfg_wr_data = '0;

    logic [THR_W-1:0] threshold;
    isect_t expected_q[$];
    int errors = 0;
    int send_idle = 0;
    int recv_idle = 0;
    bit hold_off = 1'b0;

    segment_intersection_2d i_dut (
        .clk(clk), .rst_n(rst_n),
        .s_axis_tdata(s_axis_tdata), .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data)
    );

    always #5 clk = ~clk;

    function automatic logic [FB:0] q1_div(longint num, longint den);
        longint n, d, rem;
        logic [FB:0] q;
        q = '0;
        if (num == 0) return '0;
        if ((num > 0) != (den > 0)) return '0;
        n = (num < 0) ? -num : num;
        d = (den < 0) ? -den : den;
        if (n >= d) return (FB+1)'(1) << FB;
        rem = n;
        for (int i = 0; i < FB; i++)
        begin
            rem = rem << 1;
            q = q << 1;
            if (rem >= d)
            begin
                rem -= d;
                q[0] = 1'b1;
            end
        end
        return q;
    endfunction

    function automatic bit strictly_same(longint a, longint b);
        return a != 0 && b != 0 && ((a > 0) == (b > 0));
    endfunction

    function automatic isect_t predict_isect(logic [IW-1:0] d);
        longint p[8];
        longint a1, b1, c1, a2, b2, c2, r1, r2, r3, r4, den, mg;
        isect_t r;
        for (int i = 0; i < 8; i++)
            p[i] = longint'($signed(d[i*CW +: CW]));
        r = '0;
        a1 = p[3] - p[1];  b1 = p[0] - p[2];  c1 = p[2]*p[1] - p[0]*p[3];
        r3 = a1*p[4] + b1*p[5] + c1;
        r4 = a1*p[6] + b1*p[7] + c1;
        a2 = p[7] - p[5];  b2 = p[4] - p[6];  c2 = p[6]*p[5] - p[4]*p[7];
        r1 = a2*p[0] + b2*p[1] + c2;
        r2 = a2*p[2] + b2*p[3] + c2;
        if (strictly_same(r3, r4) || strictly_same(r1, r2))
            r.status = ST_NONE;
        else
        begin
            den = a1*b2 - a2*b1;
            mg = (den < 0) ? -den : den;
            if (den == 0 || mg < longint'({29'd0, threshold}))
                r.status = ST_PARALLEL;
            else
            begin
                r.status = ST_HIT;
                r.t_frac = q1_div(-b2*(p[1]-p[5]) - a2*(p[0]-p[4]), den);
                r.u_frac = q1_div(-b1*(p[1]-p[5]) - a1*(p[0]-p[4]), den);
            end
        end
        return r;
    endfunction

    // valid stays up between back-to-back items; it drops while idling
    task automatic send_pair(logic [IW-1:0] d);
        while (send_idle > 0 && $urandom_range(99) < send_idle)
        begin
            s_axis_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_axis_tdata <= d;
        s_axis_tvalid <= 1'b1;
        expected_q.push_back(predict_isect(d));
        @(posedge clk);
        while (!s_axis_tready) @(posedge clk);
        @(negedge clk);
    endtask

    function automatic logic [IW-1:0] pack_pts(int v[8]);
        logic [IW-1:0] d;
        d = '0;
        for (int i = 0; i < 8; i++) d[i*CW +: CW] = v[i][CW-1:0];
        return d;
    endfunction

    task automatic drain;
        int guard;
        s_axis_tvalid <= 1'b0;
        guard = 0;
        while (expected_q.size() > 0 && guard < 200000)
        begin
            @(negedge clk);
            guard++;
        end
        repeat (LAT + 4) @(negedge clk);
    endtask

    task automatic write_threshold(logic [THR_W-1:0] v);
        drain();
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= v;
        threshold = v;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    // receiver side
    always @(negedge clk)
        m_axis_tready <= !hold_off && !(recv_idle > 0 && $urandom_range(99) < recv_idle);

    always @(posedge clk)
    begin
        isect_t got, exp_r;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got = {m_axis_tdata[1:0], m_axis_tdata[FB+2:2], m_axis_tdata[2*FB+3:FB+3]};
            if (expected_q.size() == 0)
            begin
                errors++;
                if (errors <= 10) $display("unexpected item %h", m_axis_tdata);
            end
            else
            begin
                exp_r = expected_q.pop_front();
                if (got !== exp_r)
                begin
                    errors++;
                    if (errors <= 10)
                        $display("mismatch: exp st=%0d t=%h u=%h got st=%0d t=%h u=%h",
                                 exp_r.status, exp_r.t_frac, exp_r.u_frac,
                                 got.status, got.t_frac, got.u_frac);
                end
            end
        end
    end

    task automatic test_directed;
        int c[][8];
        c = '{
            '{0,0,10,10, 0,10,10,0},          // crossing X
            '{0,0,10,0, 0,5,10,5},            // parallel
            '{0,0,10,0, 2,0,8,0},             // colinear overlap
            '{0,0,10,0, 20,0,30,0},           // colinear disjoint
            '{0,0,0,0, 0,0,0,0},              // degenerate points
            '{0,0,10,0, 0,5,10,1},            // same side
            '{0,0,10,0, 10,-5,10,5},          // touch at t = 1
            '{0,0,10,0, 0,-5,0,5},            // touch at t = 0
            '{0,0,10,0, 5,0,5,5},             // endpoint on line
            '{-32768,-32768,32767,32767, -32768,32767,32767,-32768},
            '{32767,-32768,-32768,32767, -32768,-32768,32767,32767},
            '{-32768,0,32767,0, 0,-32768,0,32767},
            '{0,0,3,1, 1,0,0,3},
            '{1,1,2,2, 1,2,2,1}
        };
        foreach (c[i]) send_pair(pack_pts(c[i]));
    endtask

    function automatic int rnd_coord(int mode);
        case (mode)
            0: return $urandom_range(65535) - 32768;
            1: return $urandom_range(40) - 20;
            default: return ($urandom_range(1) ? 32767 : -32768) - $urandom_range(3);
        endcase
    endfunction

    task automatic test_random(int n);
        int v[8];
        int mode;
        for (int k = 0; k < n; k++)
        begin
            mode = $urandom_range(9) < 5 ? 0 : ($urandom_range(9) < 8 ? 1 : 2);
            foreach (v[i]) v[i] = rnd_coord(mode);
            if ($urandom_range(9) == 0)
            begin
                // force colinear/parallel: second segment shifted copy of first
                v[4] = v[0] + 1; v[5] = v[1]; v[6] = v[2] + 1; v[7] = v[3];
            end
            send_pair(pack_pts(v));
        end
    endtask

    task automatic test_backpressure;
        fork
            begin
                hold_off = 1'b1;
                repeat (200) @(negedge clk);
                hold_off = 1'b0;
            end
            test_random(40);
        join
    endtask

    initial
    begin
        threshold = THR_RESET;
        repeat (9) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        send_idle = 34; recv_idle = 73;
        test_directed();
        test_random(300);
        write_threshold(35'd0);
        test_directed();
        test_random(300);
        send_idle = 73; recv_idle = 34;
        write_threshold({THR_W{1'b1}});
        test_random(150);
        write_threshold(35'h400000000);
        test_random(150);
        write_threshold(35'd1000000);
        test_random(400);
        send_idle = 0; recv_idle = 0;
        test_backpressure();
        write_threshold(35'd1);
        test_directed();
        test_random(700);
        drain();
        if (errors == 0 && expected_q.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    initial
    begin
        #3000000;
        $display("FAILURE");
        $finish;
    end
endmodule
